// ----- src/nsoes_pkg.sv -----
// Shared constants, payload structs and state encoding for the
// next-smaller-or-equal-subtract block. No dependencies.
package nsoes_pkg;

    localparam int MAX_ITEMS  = 32;  // items per sequence before overflow
    localparam int VALUE_BITS = 16;  // significant bits of an input value

    localparam int IN_VAL_W = 16;
    localparam int POS_W    = 5;
    localparam int ADJ_W    = 16;
    localparam int VAL_W    = (VALUE_BITS < IN_VAL_W) ? VALUE_BITS : IN_VAL_W;

    localparam int FILL_W = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = $clog2(MAX_ITEMS);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    // classified input item, front to back
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
        logic             fin;
        logic             ovf;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // one stack entry
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [ADJ_W-1:0] adjusted;
        logic             matched;
        logic             run_end;
        logic             seq_done;
        logic             overflow;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_FLUSH
    } t_bstate;

endpackage

// ----- src/nsoes_front.sv -----
// Input side: accepts stream transactions, counts items of the sequence and
// tags each one with its position and overflow class. Uses nsoes_pkg.
module nsoes_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [nsoes_pkg::IN_VAL_W-1:0]   i_value,
    input  logic                             i_final,
    input  nsoes_pkg::t_qstat                i_qstat,
    output logic                             o_push,
    output nsoes_pkg::t_item                 o_item
);
    import nsoes_pkg::*;

    logic [FILL_W-1:0] r_items, n_items;
    logic              w_ovf;

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && o_ready;
    assign w_ovf   = (r_items >= FILL_W'(MAX_ITEMS));

    assign o_item.value = i_value[VAL_W-1:0];
    assign o_item.pos   = POS_W'(r_items);
    assign o_item.fin   = i_final;
    assign o_item.ovf   = w_ovf;

    // a final item closes the sequence; dropped items do not count
    always_comb begin
        n_items = r_items;
        if (o_push) begin
            if (i_final) begin
                n_items = '0;
            end else if (!w_ovf) begin
                n_items = r_items + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items <= '0;
        end else begin
            r_items <= n_items;
        end
    end

endmodule

// ----- src/nsoes_queue.sv -----
// Short FIFO of classified items between the front and back parts.
// Uses nsoes_pkg.
module nsoes_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nsoes_pkg::t_item  i_item,
    input  logic              i_pop,
    output nsoes_pkg::t_item  o_item,
    output nsoes_pkg::t_qstat o_qstat
);
    import nsoes_pkg::*;

    t_item             r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_item        = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/nsoes_back.sv -----
// Execution side: holds the monotonic stack (top entry in registers, the
// rest in a memory), pops and flushes entries, and drives the output
// register. Uses nsoes_pkg.
module nsoes_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nsoes_pkg::t_qstat   i_qstat,
    input  nsoes_pkg::t_item    i_item,
    output logic                o_pop,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output nsoes_pkg::t_result  o_result
);
    import nsoes_pkg::*;

    t_bstate           r_state, n_state;
    t_item             r_cur;
    t_entry            r_top, n_top;
    t_entry            r_rd;
    t_entry            r_mem [MAX_ITEMS];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_rd_ok;
    logic              r_out_valid;
    t_result           r_out;

    logic [FILL_W-1:0] w_fill_m1;
    logic [FILL_W-1:0] w_fill_m2;
    logic              w_can_emit;
    logic              w_hit;
    logic              w_more;
    logic              w_emit;
    logic              w_do_pop;
    logic              w_do_push;
    t_result           w_res;

    assign w_fill_m1  = r_fill - FILL_W'(1);
    assign w_fill_m2  = r_fill - FILL_W'(2);
    assign w_can_emit = !r_out_valid || i_out_ready;
    assign w_hit      = (r_fill != '0) && (r_top.val >= r_cur.value);
    assign w_more     = (r_fill > FILL_W'(1)) && (r_rd.val >= r_cur.value);

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_cur.ovf) begin
                    if (r_cur.fin) begin
                        n_state = S_FLUSH;
                    end else if (w_can_emit) begin
                        n_state = S_IDLE;
                    end
                end else if (!w_hit) begin
                    n_state = r_cur.fin ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (r_fill == '0) begin
                    n_state = S_IDLE;
                end else if (w_can_emit && r_rd_ok && (r_fill == FILL_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop     = 1'b0;
        w_emit    = 1'b0;
        w_do_pop  = 1'b0;
        w_do_push = 1'b0;
        w_res     = '0;
        unique case (r_state)
            S_IDLE: begin
                o_pop = !i_qstat.empty;
            end
            S_CMP: begin
                if (r_cur.ovf) begin
                    if (!r_cur.fin) begin
                        w_emit         = w_can_emit;
                        w_res.overflow = 1'b1;
                        w_res.run_end  = 1'b1;
                    end
                end else if (w_hit) begin
                    w_emit         = w_can_emit && r_rd_ok;
                    w_do_pop       = w_emit;
                    w_res.position = r_top.pos;
                    w_res.adjusted = ADJ_W'(r_top.val - r_cur.value);
                    w_res.matched  = 1'b1;
                    w_res.run_end  = !r_cur.fin && !w_more;
                end else begin
                    w_do_push = (r_fill < FILL_W'(MAX_ITEMS));
                end
            end
            S_FLUSH: begin
                w_emit         = (r_fill != '0) && w_can_emit && r_rd_ok;
                w_do_pop       = w_emit;
                w_res.position = r_top.pos;
                w_res.adjusted = ADJ_W'(r_top.val);
                w_res.overflow = r_cur.ovf;
                w_res.run_end  = (r_fill == FILL_W'(1));
                w_res.seq_done = (r_fill == FILL_W'(1));
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    // stack pointer and top entry
    always_comb begin
        n_fill = r_fill;
        n_top  = r_top;
        if (w_do_pop) begin
            n_fill = w_fill_m1;
            n_top  = r_rd;
        end else if (w_do_push) begin
            n_fill    = r_fill + FILL_W'(1);
            n_top.pos = r_cur.pos;
            n_top.val = r_cur.value;
        end
    end

    // stack memory: old top moves down on push; read the entry below the top
    always_ff @(posedge i_clk) begin
        if (w_do_push && (r_fill != '0)) begin
            r_mem[w_fill_m1[ADDR_W-1:0]] <= r_top;
        end
        r_rd <= r_mem[w_fill_m2[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (o_pop) begin
            r_cur <= i_item;
        end
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_rd_ok     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            // read data belongs to the entry below the top only once the pointer has stopped changing
            r_rd_ok <= (n_fill == r_fill);
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- src/next_smaller_or_equal_subtract.sv -----
// Top level of the next-smaller-or-equal-subtract block: front classifier,
// item queue and stack engine. Uses nsoes_pkg, nsoes_front, nsoes_queue,
// nsoes_back.
//
//  channel   direction  tdata (low bit up)                  tlast     tuser
//  --------  ---------  ----------------------------------  --------  ----------------------
//  s (in)    slave      value[15:0]                         final     -
//  m (out)   master     position[4:0] adjusted[20:5]        run_end   seq_done[0]
//                       matched[21] zero[23:22]                       overflow[1]
//
// Flow: the front takes one transaction per cycle into a four-deep queue
// while the queue has room. The stack engine dequeues an item in S_IDLE
// and compares and pushes it in S_CMP. Each result after the first of a
// step waits for the registered read of the next stack entry from memory.
// A final item then flushes the remaining entries one by one in S_FLUSH.
// Reset (synchronous, active low) empties queue, stack and item count.
// A stalled master side holds one result in the output register while the
// engine keeps going until it needs to emit again; the front stalls only on
// a full queue.
module next_smaller_or_equal_subtract (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [nsoes_pkg::S_TDATA_W-1:0]    i_s_tdata,   // value[15:0]
    input  logic                               i_s_tlast,   // final item
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [nsoes_pkg::M_TDATA_W-1:0]    o_m_tdata,   // position, adjusted, matched
    output logic                               o_m_tlast,   // run_end
    output logic [nsoes_pkg::M_TUSER_W-1:0]    o_m_tuser    // seq_done, overflow
);
    import nsoes_pkg::*;

    t_qstat  w_qstat;
    t_item   w_in_item;
    t_item   w_q_item;
    logic    w_push;
    logic    w_pop;
    t_result w_res;

    // classify and count incoming items
    nsoes_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_value (i_s_tdata[IN_VAL_W-1:0]),
        .i_final (i_s_tlast),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_item  (w_in_item)
    );

    // decouple front and stack engine
    nsoes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_qstat (w_qstat)
    );

    // pop, push and flush the stack; own the output register
    nsoes_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_qstat     (w_qstat),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_result    (w_res)
    );

    // pack result fields onto the master side
    assign o_m_tdata = {{(M_TDATA_W - POS_W - ADJ_W - 1){1'b0}},
                        w_res.matched, w_res.adjusted, w_res.position};
    assign o_m_tlast = w_res.run_end;
    assign o_m_tuser = {w_res.overflow, w_res.seq_done};

    // the end of a sequence always closes the run of its input
    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("sequence end without run end");

    // a dropped item never reports a match
    a_ovf_unmatched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> !o_m_tdata[POS_W + ADJ_W])
        else $error("overflow result marked as matched");

    // the engine dequeues only from a non-empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue read while empty");

    // a full queue that is not read does not turn empty
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qstat.full && !w_pop) |=> !(w_qstat.empty))
        else $error("queue state lost");

endmodule

// ----- test/nsoes_checker.sv -----
// Scoreboard for next_smaller_or_equal_subtract: watches both stream channels,
// tracks the monotonic stack on its own and compares every output transaction.
// Depends on nsoes_pkg for widths and the result layout.
`timescale 1ns / 1ps

module nsoes_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [nsoes_pkg::S_TDATA_W-1:0] i_s_tdata,   // value[15:0]
    input  logic                            i_s_tlast,   // final item
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [nsoes_pkg::M_TDATA_W-1:0] i_m_tdata,   // position, adjusted, matched, zero pad
    input  logic                            i_m_tlast,   // run_end
    input  logic [nsoes_pkg::M_TUSER_W-1:0] i_m_tuser,   // seq_done, overflow
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_items_taken,
    output int                              o_results_checked
);
    import nsoes_pkg::*;

    localparam int PAD_LO = POS_W + ADJ_W + 1;

    // shadow of the unresolved entries, bottom at index 0
    logic [POS_W-1:0] open_pos [MAX_ITEMS];
    logic [VAL_W-1:0] open_val [MAX_ITEMS];
    int               open_fill  = 0;
    int               seq_taken  = 0;

    t_result          due_results[$];
    int               errors      = 0;
    int               items_in    = 0;
    int               results_in  = 0;
    int               pending_cnt = 0;

    assign o_errors          = errors;
    assign o_pending         = pending_cnt;
    assign o_items_taken     = items_in;
    assign o_results_checked = results_in;

    // pop everything left, top first, at full value; closes the sequence
    task automatic drain_stack(input logic ovf);
        t_result r;
        while (open_fill > 0) begin
            open_fill--;
            r          = '0;
            r.position = open_pos[open_fill];
            r.adjusted = open_val[open_fill];
            r.overflow = ovf;
            due_results.push_back(r);
        end
        r          = due_results.pop_back();
        r.seq_done = 1'b1;
        due_results.push_back(r);
        open_fill = 0;
        seq_taken = 0;
    endtask

    // work out every result that one input transaction causes
    task automatic resolve_item(input logic [VAL_W-1:0] val, input logic fin);
        t_result r;
        int      first;
        first = due_results.size();
        if (seq_taken >= MAX_ITEMS) begin
            // beyond capacity: drop the value, but a final mark still closes
            if (fin) begin
                drain_stack(1'b1);
            end else begin
                r          = '0;
                r.overflow = 1'b1;
                due_results.push_back(r);
            end
        end else begin
            while (open_fill > 0 && open_val[open_fill-1] >= val) begin
                open_fill--;
                r          = '0;
                r.position = open_pos[open_fill];
                r.adjusted = open_val[open_fill] - val;
                r.matched  = 1'b1;
                due_results.push_back(r);
            end
            open_pos[open_fill] = seq_taken[POS_W-1:0];
            open_val[open_fill] = val;
            open_fill++;
            seq_taken++;
            if (fin) begin
                drain_stack(1'b0);
            end
        end
        if (due_results.size() > first) begin
            r         = due_results.pop_back();
            r.run_end = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic check_field(input string what, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual tdata %h tlast %b tuser %b",
                     $time, i_m_tdata, i_m_tlast, i_m_tuser);
            errors++;
        end else begin
            want = due_results.pop_front();
            check_field("position", int'(want.position), int'(i_m_tdata[POS_W-1:0]));
            check_field("adjusted", int'(want.adjusted), int'(i_m_tdata[POS_W +: ADJ_W]));
            check_field("matched",  int'(want.matched),  int'(i_m_tdata[POS_W+ADJ_W]));
            check_field("tdata pad", 0, int'(i_m_tdata[M_TDATA_W-1:PAD_LO]));
            check_field("run_end",  int'(want.run_end),  int'(i_m_tlast));
            check_field("seq_done", int'(want.seq_done), int'(i_m_tuser[0]));
            check_field("overflow", int'(want.overflow), int'(i_m_tuser[1]));
        end
        results_in++;
    endtask

    // outputs first, so a result can never be matched to an input of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_fill = 0;
            seq_taken = 0;
            due_results.delete();
            pending_cnt = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                compare_result();
            end
            if (i_s_tvalid && i_s_tready) begin
                resolve_item(i_s_tdata[VAL_W-1:0], i_s_tlast);
                items_in++;
            end
            pending_cnt = due_results.size();
        end
    end

endmodule

// ----- test/tb_next_smaller_or_equal_subtract.sv -----
// Top of the next_smaller_or_equal_subtract testbench: clock, reset, stream
// stimulus and output back-pressure. Uses nsoes_pkg, nsoes_checker and the block.
`timescale 1ns / 1ps

module tb_next_smaller_or_equal_subtract;
    import nsoes_pkg::*;

    localparam int TOTAL_ITEMS  = 380;
    localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for the last results
    localparam int TAIL_CYCLES  = 40;     // settle time after the last result

    typedef logic [IN_VAL_W-1:0] t_values[$];

    typedef enum int {
        PAT_FULL,     // uniform over the whole value range
        PAT_NARROW,   // few distinct values, many equal neighbors
        PAT_RISING,   // deep stacks, ended by a small value
        PAT_FALLING,  // pops on nearly every item
        PAT_EXTREME   // only zero and all ones
    } t_pattern;

    logic                 i_clk;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;   // value[15:0]
    logic                 i_s_tlast  = 1'b0; // final item
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;         // position[4:0] adjusted[20:5] matched[21]
    logic                 o_m_tlast;         // run_end
    logic [M_TUSER_W-1:0] o_m_tuser;         // seq_done[0] overflow[1]

    int errors;
    int pending;
    int items_taken;
    int results_checked;

    // when set, neither side idles: back-to-back transactions
    logic steady_flow = 1'b0;

    int items_sent     = 0;
    int sequences_sent = 0;
    int overflow_items = 0;

    next_smaller_or_equal_subtract u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    nsoes_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_s_tlast         (i_s_tlast),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tlast         (o_m_tlast),
        .i_m_tuser         (o_m_tuser),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_items_taken     (items_taken),
        .o_results_checked (results_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one transaction on the slave side and hold it until accepted.
    // tvalid stays high when no gap follows, so it is never dropped and
    // raised within one step.
    task automatic send_value(input logic [IN_VAL_W-1:0] val, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= val;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // send a whole sequence, the final mark on its last element
    task automatic play_sequence(input t_values vals);
        for (int i = 0; i < vals.size(); i++) begin
            if (i >= MAX_ITEMS) overflow_items++;
            send_value(vals[i], i == vals.size() - 1);
        end
        sequences_sent++;
    endtask

    function automatic logic [IN_VAL_W-1:0] next_value(input t_pattern pat,
                                                       input logic [IN_VAL_W-1:0] prev,
                                                       input bit is_final);
        case (pat)
            PAT_NARROW:  return IN_VAL_W'($urandom_range(0, 7));
            // end low so the final item pops as much of the stack as it can
            PAT_RISING:  return is_final ? IN_VAL_W'($urandom_range(0, 3))
                                         : prev + IN_VAL_W'($urandom_range(0, 2000));
            PAT_FALLING: return prev - IN_VAL_W'($urandom_range(0, 2000));
            PAT_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            default:     return IN_VAL_W'($urandom);
        endcase
    endfunction

    // Back-pressure on the master side: bursts of ready, then a stall.
    initial begin
        int burst;
        int hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            i_m_tready <= 1'b1;
            burst = $urandom_range(1, 24);
            repeat (burst) @(posedge i_clk);
            hold = pick_gap();
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_values    vals;
        t_pattern   pat;
        int         len;
        int         r;
        int         waited;
        logic [IN_VAL_W-1:0] prev;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: final item on an empty sequence, at both value extremes
        vals = {16'h0000};
        play_sequence(vals);
        vals = {16'hFFFF};
        play_sequence(vals);
        // a smaller value, an equal value (difference zero), a push with no
        // pops, then a final minimum that pops the rest
        vals = {16'd5, 16'd3, 16'd3, 16'hFFFF, 16'h0000};
        play_sequence(vals);
        // rising values: nothing resolves until the final flush
        vals = {16'd1, 16'd2, 16'd3, 16'd7};
        play_sequence(vals);
        // largest possible difference, then no pop ahead of the flush
        vals = {16'hFFFF, 16'h0000};
        play_sequence(vals);
        vals = {16'h0000, 16'hFFFF};
        play_sequence(vals);

        // Random sequences: mostly short, some deep, some past capacity so
        // both the dropped plain item and the dropped final item show up
        while (items_sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 65)      len = $urandom_range(1, 8);
            else if (r < 85) len = $urandom_range(9, MAX_ITEMS - 1);
            else             len = $urandom_range(MAX_ITEMS, MAX_ITEMS + 4);
            pat  = t_pattern'($urandom_range(0, 4));
            prev = IN_VAL_W'($urandom);
            if (pat == PAT_RISING) prev = IN_VAL_W'($urandom_range(0, 255));
            vals.delete();
            for (int i = 0; i < len; i++) begin
                prev = next_value(pat, prev, i == len - 1);
                vals.push_back(prev);
            end
            // every fifth sequence or so runs without any idling
            steady_flow <= ($urandom_range(0, 4) == 0);
            play_sequence(vals);
        end
        i_s_tvalid  <= 1'b0;
        steady_flow <= 1'b0;

        // drain: every transaction counted and every expectation met
        waited = 0;
        while ((items_taken != items_sent || pending != 0) && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d items in %0d sequences (%0d past capacity), %0d results checked.",
                 items_sent, sequences_sent, overflow_items, results_checked);
        if (errors == 0 && pending == 0 && items_taken == items_sent) begin
            $display("next_smaller_or_equal_subtract test passed");
        end else begin
            if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
            $display("next_smaller_or_equal_subtract test failed");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #60_000_000;
        $display("%0t: timeout", $time);
        $display("next_smaller_or_equal_subtract test failed");
        $finish;
    end

endmodule

// ----- next_smaller_or_equal_subtract.f -----
src/nsoes_pkg.sv
src/nsoes_front.sv
src/nsoes_queue.sv
src/nsoes_back.sv
src/next_smaller_or_equal_subtract.sv
test/nsoes_checker.sv
test/tb_next_smaller_or_equal_subtract.sv
